FILE: sv/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Shared widths, default sizes, operation and status codes.
// ----------------------------------------------------------------------------
package fba_pkg;

  // Default sizing of the frame bitmap.
  localparam int unsigned FBA_MAX_FRAMES = 32768;
  localparam int unsigned FBA_PAGE_BYTES = 4096;
  localparam int unsigned FBA_WORD_BITS  = 32;
  localparam int unsigned FBA_CELLS      = 8;

  // Fixed field widths.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned FIDX_W   = 15;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FCOUNT_W = 16;

  localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 16'd32768;

  typedef enum logic [FUNC_W-1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_TEST  = 2'd2
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_NOOP    = 2'd1,
    ST_NOFRAME = 2'd2
  } status_e;

endpackage

FILE: sv/fba_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator request channel
// Valid/ready channel that carries one allocator operation.
// ----------------------------------------------------------------------------
interface fba_req_if;
  import fba_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [FIDX_W-1:0] page_frame;
  logic [ADDR_W-1:0] byte_addr;
  logic              kernel_page;
  logic              rw_page;

  modport source (
    output valid, func, page_frame, byte_addr, kernel_page, rw_page,
    input  ready
  );

  modport sink (
    input  valid, func, page_frame, byte_addr, kernel_page, rw_page,
    output ready
  );

endinterface

FILE: sv/fba_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator response channel
// Valid/ready channel that carries the result of one operation.
// ----------------------------------------------------------------------------
interface fba_rsp_if;
  import fba_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIDX_W-1:0]   frame_index;
  logic                present;
  logic                writable;
  logic                user_mode;
  logic                frame_used;

  modport source (
    output valid, status, frame_index, present, writable, user_mode, frame_used,
    input  ready
  );

  modport sink (
    input  valid, status, frame_index, present, writable, user_mode, frame_used,
    output ready
  );

endinterface

FILE: sv/fba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator search cell
// Holds the full flags of a slice of bitmap words and passes the search
// token, with the lowest non-full word seen so far, to its neighbor.
// ----------------------------------------------------------------------------
module fba_cell #(
  parameter int unsigned AW        = 10,
  parameter int unsigned SLICE     = 128,
  parameter int unsigned BASE      = 0,
  parameter int unsigned NUM_WORDS = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          upd_en_i,
  input  logic [AW-1:0] upd_word_i,
  input  logic          upd_full_i,
  input  logic          tok_i,
  input  logic          hit_i,
  input  logic [AW-1:0] word_i,
  output logic          tok_o,
  output logic          hit_o,
  output logic [AW-1:0] word_o
);

  localparam int unsigned SW = (SLICE > 1) ? $clog2(SLICE) : 1;

  logic [SLICE-1:0] full_q;
  logic [SLICE-1:0] in_mask;
  logic [SLICE-1:0] free_v;
  logic [SLICE-1:0] low_v;
  logic [SW-1:0]    low_idx;
  logic             any_free;
  logic [AW-1:0]    local_word;
  logic             tok_q;
  logic             hit_q;
  logic [AW-1:0]    word_q;

  // Words past the end of the bitmap never count as free.
  always_comb begin
    for (int k = 0; k < SLICE; k++) begin
      in_mask[k] = ((BASE + k) < NUM_WORDS);
    end
  end

  assign free_v   = ~full_q & in_mask;
  assign low_v    = free_v & (~free_v + SLICE'(1));
  assign any_free = |free_v;

  always_comb begin
    low_idx = '0;
    for (int k = 0; k < SLICE; k++) begin
      for (int j = 0; j < SW; j++) begin
        low_idx[j] = low_idx[j] | (low_v[k] & k[j]);
      end
    end
  end

  assign local_word = AW'(BASE) + AW'(low_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (upd_en_i) begin
      for (int k = 0; k < SLICE; k++) begin
        if (32'(upd_word_i) == 32'(BASE + k)) begin
          full_q[k] <= upd_full_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= 1'b0;
      hit_q  <= 1'b0;
      word_q <= '0;
    end else begin
      tok_q <= tok_i;
      if (tok_i) begin
        hit_q  <= hit_i | any_free;
        word_q <= hit_i ? word_i : local_word;
      end
    end
  end

  assign tok_o  = tok_q;
  assign hit_o  = hit_q;
  assign word_o = word_q;

endmodule

FILE: sv/frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// Physical page-frame allocator over a bitmap of used frames.
// ----------------------------------------------------------------------------
// Usage: operations arrive as transactions on req_i (allocate, free, test
// address) and each one produces exactly one result transaction on rsp_o.
// The frame_count register is written through cfg_we_i / cfg_wdata_i; the
// user must do so only while the block is idle; the block does not enforce it.
//
// One operation is in flight at a time. An allocation walks the search
// token down the chain of summary cells one cell per cycle; the lowest
// non-full word is then read and, if wholly below frame_count, updated
// and written back. Free and test divide the frame by the word size (test
// first divides the byte address by the page size) and read the word;
// free writes it back. Allocating for a page that already holds a frame,
// freeing frame zero and an unused code go straight to the result.
//
// After reset all NUM_WORDS bitmap words (1024 by default) are cleared one
// word per cycle, with req_i not ready; frame_count resets to 32768. The
// result sits in an output register, so a stalled receiver does not stop
// the next transaction from being accepted; only the following result
// waits for the register to drain.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
  parameter int unsigned MAX_FRAMES = fba_pkg::FBA_MAX_FRAMES,
  parameter int unsigned PAGE_BYTES = fba_pkg::FBA_PAGE_BYTES,
  parameter int unsigned WORD_BITS  = fba_pkg::FBA_WORD_BITS,
  parameter int unsigned CELLS      = fba_pkg::FBA_CELLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fba_pkg::FCOUNT_W-1:0]  cfg_wdata_i,
  fba_req_if.sink                       req_i,
  fba_rsp_if.source                     rsp_o
);
  import fba_pkg::*;

  // Bitmap geometry.
  localparam int unsigned NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned BW        = $clog2(WORD_BITS);
  localparam int unsigned WBW       = $clog2(WORD_BITS + 1);
  localparam int unsigned SLICE     = (NUM_WORDS + CELLS - 1) / CELLS;

  // Frame numbers held internally; wide enough for a byte address divided
  // by the page size and for any page_frame value.
  localparam int unsigned L_PG  = $clog2(PAGE_BYTES);
  localparam int unsigned FRW_A = ADDR_W + 1 - L_PG;
  localparam int unsigned FRW   = (FRW_A > FIDX_W + 2) ? FRW_A : FIDX_W + 2;

  // Reciprocals for the divisions by the page size and by the word size:
  // q = (x * ceil(2^(N+L) / d)) >> (N+L) is exact for every N-bit x.
  localparam int unsigned PG_SH = ADDR_W + L_PG;
  localparam logic [63:0] M_PG  =
    ((64'd1 << PG_SH) + 64'(PAGE_BYTES) - 64'd1) / 64'(PAGE_BYTES);
  localparam int unsigned PGPW  = 2 * ADDR_W + 1;
  localparam int unsigned WD_SH = FRW + BW;
  localparam logic [63:0] M_WB  =
    ((64'd1 << WD_SH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
  localparam int unsigned WDPW  = 2 * FRW + 1;

  // Widths of the limit compare and the allocated frame number.
  localparam int unsigned CW_A = AW + 1 + WBW;
  localparam int unsigned CMPW = (CW_A > FCOUNT_W) ? CW_A : FCOUNT_W;
  localparam int unsigned FA_A = AW + WBW + 1;
  localparam int unsigned FAW  = (FA_A > FIDX_W + 1) ? FA_A : FIDX_W + 1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVW,
    S_DIVB,
    S_FETCH,
    S_SCAN,
    S_ELIG,
    S_PICK,
    S_RESP
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       clr_q;
  logic [FCOUNT_W-1:0] fcount_q;

  // Operation context.
  logic [FUNC_W-1:0]   op_q;
  logic                kern_q;
  logic                wr_q;
  logic [FRW-1:0]      frame_q;
  logic [FRW-1:0]      word_q;
  logic [BW-1:0]       bit_q;
  logic                in_range_q;
  logic                hit_q;
  logic                elig_q;

  // Pending result and output register.
  logic [STATUS_W-1:0] res_status_q;
  logic [FIDX_W-1:0]   res_fidx_q;
  logic                res_pres_q;
  logic                res_wr_q;
  logic                res_user_q;
  logic                res_used_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [FIDX_W-1:0]   out_fidx_q;
  logic                out_pres_q;
  logic                out_wr_q;
  logic                out_user_q;
  logic                out_used_q;

  // Bitmap memory.
  logic [WORD_BITS-1:0] bitmap_q [NUM_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;

  // Summary chain.
  logic [CELLS:0] tok_w;
  logic [CELLS:0] hit_w;
  logic [AW-1:0]  word_w [CELLS+1];
  logic           scan_start;
  logic           upd_en;
  logic           upd_full;

  logic                 accept;
  logic [PGPW-1:0]      pg_prod;
  logic [WDPW-1:0]      wd_prod;
  logic [FRW-1:0]       word_mul;
  logic [CMPW-1:0]      lim_need;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] low_bit;
  logic [WORD_BITS-1:0] set_word;
  logic [WORD_BITS-1:0] clr_word;
  logic [BW-1:0]        low_idx;
  logic [FAW-1:0]       pick_frame;
  logic                 alloc_ok;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign scan_start  = accept && (req_i.func == FN_ALLOC) && (req_i.page_frame == '0);

  // Frame of a byte address, and word of a frame.
  assign pg_prod  = PGPW'(req_i.byte_addr) * PGPW'(M_PG[ADDR_W:0]);
  assign wd_prod  = WDPW'(frame_q) * WDPW'(M_WB[FRW:0]);
  assign word_mul = FRW'(word_q * FRW'(WORD_BITS));

  // A word may be allocated from only if it lies wholly below frame_count.
  // The cells return the lowest non-full word; the limit is a prefix, so
  // checking that one word is enough.
  assign lim_need = CMPW'({1'b0, word_q[AW-1:0]} + 1'b1) * CMPW'(WORD_BITS);

  // Lowest clear bit of the fetched word.
  assign free_bits = ~rdata_q;
  assign low_bit   = free_bits & (~free_bits + WORD_BITS'(1));
  assign set_word  = rdata_q | low_bit;
  assign clr_word  = rdata_q & ~(WORD_BITS'(1) << bit_q);

  always_comb begin
    low_idx = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      for (int j = 0; j < BW; j++) begin
        low_idx[j] = low_idx[j] | (low_bit[k] & k[j]);
      end
    end
  end

  assign pick_frame = FAW'(word_q[AW-1:0]) * FAW'(WORD_BITS) + FAW'(low_idx);
  assign alloc_ok   = elig_q && (|free_bits);

  // Memory write and summary update for the current state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = word_q[AW-1:0];
    mem_wdata = set_word;
    upd_en    = 1'b0;
    upd_full  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      S_FETCH: begin
        if ((op_q == FN_FREE) && in_range_q) begin
          mem_we    = 1'b1;
          mem_wdata = clr_word;
          upd_en    = 1'b1;
          upd_full  = 1'b0;
        end
      end
      S_PICK: begin
        if (alloc_ok) begin
          mem_we   = 1'b1;
          upd_en   = 1'b1;
          upd_full = &set_word;
        end
      end
      default: begin
      end
    endcase
  end

  assign mem_raddr = word_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= bitmap_q[mem_raddr];
  end

  // Chain of summary cells; the token enters cell zero with no hit.
  assign tok_w[0]  = scan_start;
  assign hit_w[0]  = 1'b0;
  assign word_w[0] = '0;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    fba_cell #(
      .AW        (AW),
      .SLICE     (SLICE),
      .BASE      (g * SLICE),
      .NUM_WORDS (NUM_WORDS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .upd_en_i   (upd_en),
      .upd_word_i (word_q[AW-1:0]),
      .upd_full_i (upd_full),
      .tok_i      (tok_w[g]),
      .hit_i      (hit_w[g]),
      .word_i     (word_w[g]),
      .tok_o      (tok_w[g+1]),
      .hit_o      (hit_w[g+1]),
      .word_o     (word_w[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= FCOUNT_RST;
    end else if (cfg_we_i) begin
      fcount_q <= cfg_wdata_i;
    end
  end

  // Sequencer with the result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // In S_RESP the output register is handled by the state itself.
      if (out_valid_q && rsp_o.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(NUM_WORDS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q         <= req_i.func;
            kern_q       <= req_i.kernel_page;
            wr_q         <= req_i.rw_page;
            res_status_q <= ST_NOOP;
            // An allocation for a mapped page echoes its frame.
            res_fidx_q   <= (req_i.func == FN_ALLOC) ? req_i.page_frame : '0;
            res_pres_q   <= 1'b0;
            res_wr_q     <= 1'b0;
            res_user_q   <= 1'b0;
            res_used_q   <= 1'b0;
            unique case (req_i.func)
              FN_ALLOC: begin
                if (req_i.page_frame != '0) begin
                  state_q <= S_RESP;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              FN_FREE: begin
                if (req_i.page_frame != '0) begin
                  frame_q <= FRW'(req_i.page_frame);
                  state_q <= S_DIVW;
                end else begin
                  state_q <= S_RESP;
                end
              end
              FN_TEST: begin
                frame_q <= FRW'(pg_prod >> PG_SH);
                state_q <= S_DIVW;
              end
              default: begin
                state_q <= S_RESP;
              end
            endcase
          end
        end
        S_DIVW: begin
          word_q     <= FRW'(wd_prod >> WD_SH);
          in_range_q <= (32'(frame_q) < 32'(MAX_FRAMES));
          state_q    <= S_DIVB;
        end
        S_DIVB: begin
          // The bitmap read of word_q is issued in this cycle.
          bit_q   <= BW'(frame_q - word_mul);
          state_q <= S_FETCH;
        end
        S_FETCH: begin
          res_status_q <= ST_DONE;
          if (op_q == FN_TEST) begin
            res_used_q <= in_range_q & rdata_q[bit_q];
          end
          state_q <= S_RESP;
        end
        S_SCAN: begin
          if (tok_w[CELLS]) begin
            hit_q   <= hit_w[CELLS];
            word_q  <= FRW'(word_w[CELLS]);
            state_q <= S_ELIG;
          end
        end
        S_ELIG: begin
          // The bitmap read of the candidate word is issued in this cycle.
          elig_q  <= hit_q && (lim_need <= CMPW'(fcount_q));
          state_q <= S_PICK;
        end
        S_PICK: begin
          if (alloc_ok) begin
            res_status_q <= ST_DONE;
            res_fidx_q   <= pick_frame[FIDX_W-1:0];
            res_pres_q   <= 1'b1;
            res_wr_q     <= wr_q;
            res_user_q   <= ~kern_q;
          end else begin
            res_status_q <= ST_NOFRAME;
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_fidx_q   <= res_fidx_q;
            out_pres_q   <= res_pres_q;
            out_wr_q     <= res_wr_q;
            out_user_q   <= res_user_q;
            out_used_q   <= res_used_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.frame_index = out_fidx_q;
  assign rsp_o.present     = out_pres_q;
  assign rsp_o.writable    = out_wr_q;
  assign rsp_o.user_mode   = out_user_q;
  assign rsp_o.frame_used  = out_used_q;

endmodule
